// File: rtl/segment_box_overlap_test_assert.svh
// ----------------------------------------------------------------------------
// Segment box overlap test assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_OVERLAP_TEST_ASSERT_SVH
`define SEGMENT_BOX_OVERLAP_TEST_ASSERT_SVH

`ifndef SYNTHESIS

// cond holds in the same cycle as ante
`define SBOT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond holds in the cycle after ante
`define SBOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SBOT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SBOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/sbot_pkg.sv
// ----------------------------------------------------------------------------
// Segment box overlap test package
// Fixed field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbot_pkg;

    localparam int COORD_W   = 32;   // origin, direction, box corners
    localparam int LEN_W     = 31;   // unsigned segment length
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int H_W       = 33;   // box half extent, signed
    localparam int PP_LO_W   = 32;   // low slice of a partial product operand

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

    // default box is -0.5 .. +0.5 in Q16.16
    localparam logic signed [COORD_W-1:0] BOX_MIN_RST = -32'sd32768;
    localparam logic signed [COORD_W-1:0] BOX_MAX_RST = 32'sd32768;

    typedef logic signed [COORD_W-1:0] t_coord;

endpackage

`default_nettype wire

// File: rtl/segment_box_overlap_test.sv
// ----------------------------------------------------------------------------
// Segment versus axis-aligned box overlap test
// Separating axis test of one segment per item against a configured box,
// eight register stages, one item per cycle while the output does not stall.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready    | origin_x/y/z, dir_x/y/z, len
//  out     | output    | o_out_valid / i_out_ready  | hit
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_addr, i_cfg_wdata
//
//  Throughput is one item per cycle while the output does not stall; an
//  accepted item reaches o_out_valid through the eight stage chain: capture, |dir|*len, midpoint,
//  axis tests, partial products, product sums, cross terms, final compare.
//  Reset clears all stage valid bits and loads the box with -0.5 .. +0.5.
//  Each stage holds while the one after it is full and stalled; empty
//  stages fill, so input is taken until every stage holds an item.
//
//  Geometry is carried at twice the input scale so the box centre and half
//  extents stay exact: d = sign(dir)*((|dir|*len) >> FRAC_BITS),
//  m = 2*origin + d - (min + max), h = max - min.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "segment_box_overlap_test_assert.svh"

module segment_box_overlap_test #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_we,
    input  wire  [sbot_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire  [sbot_pkg::CFG_W-1:0]           i_cfg_wdata,
    // segment items
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [sbot_pkg::COORD_W-1:0]  i_origin_x,
    input  wire  signed [sbot_pkg::COORD_W-1:0]  i_origin_y,
    input  wire  signed [sbot_pkg::COORD_W-1:0]  i_origin_z,
    input  wire  signed [sbot_pkg::COORD_W-1:0]  i_dir_x,
    input  wire  signed [sbot_pkg::COORD_W-1:0]  i_dir_y,
    input  wire  signed [sbot_pkg::COORD_W-1:0]  i_dir_z,
    input  wire  [sbot_pkg::LEN_W-1:0]           i_seg_length,
    // results
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_hit
);

    localparam int CW    = sbot_pkg::COORD_W;
    localparam int HW    = sbot_pkg::H_W;
    localparam int LO_W  = sbot_pkg::PP_LO_W;
    localparam int PROD_W = CW + sbot_pkg::LEN_W;    // |dir| * len
    localparam int DM_W  = PROD_W - FRAC_BITS;        // |d|
    localparam int D_W   = DM_W + 1;                  // signed d
    localparam int M_W   = DM_W + 3;                  // signed m
    localparam int OP_W  = M_W;                       // product operand magnitude
    localparam int HI_W  = OP_W - LO_W;
    localparam int P_W   = 2 * OP_W;                  // product magnitude
    localparam int S_W   = P_W + 2;                   // cross terms, signed
    localparam int NST   = 8;

    // ------------------------------------------------------------------
    // Box registers
    // ------------------------------------------------------------------
    sbot_pkg::t_coord r_box_min [3];
    sbot_pkg::t_coord r_box_max [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_box_min[i] <= sbot_pkg::BOX_MIN_RST;
                r_box_max[i] <= sbot_pkg::BOX_MAX_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sbot_pkg::CFG_MIN_X: r_box_min[0] <= i_cfg_wdata;
                sbot_pkg::CFG_MIN_Y: r_box_min[1] <= i_cfg_wdata;
                sbot_pkg::CFG_MIN_Z: r_box_min[2] <= i_cfg_wdata;
                sbot_pkg::CFG_MAX_X: r_box_max[0] <= i_cfg_wdata;
                sbot_pkg::CFG_MAX_Y: r_box_max[1] <= i_cfg_wdata;
                sbot_pkg::CFG_MAX_Z: r_box_max[2] <= i_cfg_wdata;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // The user keeps the box static while items are in flight; the block does not
    // enforce it. Centre sum and half extent are taken straight from the registers.
    logic signed [M_W-1:0] n_csum [3];
    logic signed [HW-1:0]  n_half [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_csum[i] = M_W'(r_box_min[i]) + M_W'(r_box_max[i]);
            n_half[i] = HW'(r_box_max[i]) - HW'(r_box_min[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [NST:1] r_v;
    logic [NST:1] en;

    always_comb begin
        en[NST] = !r_v[NST] || i_out_ready;
        for (int s = NST - 1; s >= 1; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int s = 2; s <= NST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign o_in_ready  = en[1];
    assign o_out_valid = r_v[NST];

    // ------------------------------------------------------------------
    // Stage 1: capture
    // ------------------------------------------------------------------
    sbot_pkg::t_coord            r1_o   [3];
    sbot_pkg::t_coord            r1_dir [3];
    logic [sbot_pkg::LEN_W-1:0]  r1_len;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_o[0]   <= i_origin_x;
            r1_o[1]   <= i_origin_y;
            r1_o[2]   <= i_origin_z;
            r1_dir[0] <= i_dir_x;
            r1_dir[1] <= i_dir_y;
            r1_dir[2] <= i_dir_z;
            r1_len    <= i_seg_length;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: |dir| * len
    // ------------------------------------------------------------------
    logic [CW-1:0]     n2_adir [3];
    logic [PROD_W-1:0] r2_prod [3];
    logic              r2_dneg [3];
    sbot_pkg::t_coord  r2_o    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // -(-2^31) wraps to 0x80000000, which is right as unsigned
            n2_adir[i] = r1_dir[i][CW-1] ? CW'(-r1_dir[i]) : CW'(r1_dir[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_prod[i] <= PROD_W'(n2_adir[i]) * PROD_W'(r1_len);
                r2_dneg[i] <= r1_dir[i][CW-1];
                r2_o[i]    <= r1_o[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: half vector d and midpoint offset m
    // ------------------------------------------------------------------
    logic [DM_W-1:0]        n3_dm [3];
    logic signed [D_W-1:0]  n3_d  [3];
    logic signed [M_W-1:0]  n3_m  [3];
    logic [DM_W-1:0]        r3_ad [3];
    logic signed [D_W-1:0]  r3_d  [3];
    logic signed [M_W-1:0]  r3_m  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_dm[i] = r2_prod[i][PROD_W-1:FRAC_BITS];
            n3_d[i]  = r2_dneg[i] ? -$signed({1'b0, n3_dm[i]}) : $signed({1'b0, n3_dm[i]});
            n3_m[i]  = (M_W'(r2_o[i]) <<< 1) + M_W'(n3_d[i]) - n_csum[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r3_ad[i] <= n3_dm[i];
                r3_d[i]  <= n3_d[i];
                r3_m[i]  <= n3_m[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: world axis tests, magnitudes and signs for the cross axes
    // ------------------------------------------------------------------
    logic [M_W-1:0]         n4_mm  [3];
    logic [HW-1:0]          n4_hm  [3];
    logic signed [M_W:0]    n4_rhs [3];
    logic [2:0]             n4_sep;
    logic [2:0]             r4_sep;
    logic [OP_W-1:0]        r4_mm [3];
    logic [OP_W-1:0]        r4_dm [3];
    logic [OP_W-1:0]        r4_hm [3];
    logic                   r4_ms [3];
    logic                   r4_ds [3];
    logic                   r4_hs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_mm[i]  = r3_m[i][M_W-1] ? M_W'(-r3_m[i]) : M_W'(r3_m[i]);
            n4_hm[i]  = n_half[i][HW-1] ? HW'(-n_half[i]) : HW'(n_half[i]);
            // inverted box gives a negative half extent, used as is
            n4_rhs[i] = (M_W+1)'(n_half[i]) + (M_W+1)'($signed({1'b0, r3_ad[i]}));
            n4_sep[i] = $signed({1'b0, n4_mm[i]}) > n4_rhs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sep <= n4_sep;
            for (int i = 0; i < 3; i++) begin
                r4_mm[i] <= OP_W'(n4_mm[i]);
                r4_dm[i] <= OP_W'(r3_ad[i]);
                r4_hm[i] <= OP_W'(n4_hm[i]);
                r4_ms[i] <= r3_m[i][M_W-1];
                r4_ds[i] <= r3_d[i][D_W-1];
                r4_hs[i] <= n_half[i][HW-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: partial products for the three cross axes
    // Axis k uses the pair (a, b) = (1,2), (2,0), (0,1); terms are
    // ma*db, mb*da, ha*|db|, hb*|da|.
    // ------------------------------------------------------------------
    logic [OP_W-1:0]        n_opa  [3][4];
    logic [OP_W-1:0]        n_opb  [3][4];
    logic                   n_pneg [3][4];
    logic [2*LO_W-1:0]      r5_pll [3][4];
    logic [LO_W+HI_W-1:0]   r5_plh [3][4];
    logic [LO_W+HI_W-1:0]   r5_phl [3][4];
    logic [2*HI_W-1:0]      r5_phh [3][4];
    logic                   r5_neg [3][4];
    logic [2:0]             r5_sep;

    always_comb begin
        int ia;
        int ib;
        for (int k = 0; k < 3; k++) begin
            ia = (k == 2) ? 0 : k + 1;
            ib = (k == 0) ? 2 : k - 1;
            n_opa[k][0] = r4_mm[ia];  n_opb[k][0] = r4_dm[ib];
            n_pneg[k][0] = r4_ms[ia] ^ r4_ds[ib];
            n_opa[k][1] = r4_mm[ib];  n_opb[k][1] = r4_dm[ia];
            n_pneg[k][1] = r4_ms[ib] ^ r4_ds[ia];
            n_opa[k][2] = r4_hm[ia];  n_opb[k][2] = r4_dm[ib];
            n_pneg[k][2] = r4_hs[ia];
            n_opa[k][3] = r4_hm[ib];  n_opb[k][3] = r4_dm[ia];
            n_pneg[k][3] = r4_hs[ib];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_sep <= r4_sep;
            for (int k = 0; k < 3; k++) begin
                for (int p = 0; p < 4; p++) begin
                    r5_pll[k][p] <= (2*LO_W)'(n_opa[k][p][LO_W-1:0])
                                  * (2*LO_W)'(n_opb[k][p][LO_W-1:0]);
                    r5_plh[k][p] <= (LO_W+HI_W)'(n_opa[k][p][LO_W-1:0])
                                  * (LO_W+HI_W)'(n_opb[k][p][OP_W-1:LO_W]);
                    r5_phl[k][p] <= (LO_W+HI_W)'(n_opa[k][p][OP_W-1:LO_W])
                                  * (LO_W+HI_W)'(n_opb[k][p][LO_W-1:0]);
                    r5_phh[k][p] <= (2*HI_W)'(n_opa[k][p][OP_W-1:LO_W])
                                  * (2*HI_W)'(n_opb[k][p][OP_W-1:LO_W]);
                    r5_neg[k][p] <= n_pneg[k][p];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: partial products summed to full magnitudes
    // ------------------------------------------------------------------
    logic [P_W-1:0] r6_mag [3][4];
    logic           r6_neg [3][4];
    logic [2:0]     r6_sep;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_sep <= r5_sep;
            for (int k = 0; k < 3; k++) begin
                for (int p = 0; p < 4; p++) begin
                    r6_mag[k][p] <= P_W'(r5_pll[k][p])
                                  + (P_W'(r5_plh[k][p]) << LO_W)
                                  + (P_W'(r5_phl[k][p]) << LO_W)
                                  + (P_W'(r5_phh[k][p]) << (2 * LO_W));
                    r6_neg[k][p] <= r5_neg[k][p];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: signed cross terms, lhs = ma*db - mb*da, rhs = h terms
    // ------------------------------------------------------------------
    logic signed [P_W:0]   n7_sp [3][4];
    logic signed [S_W-1:0] r7_lhs [3];
    logic signed [S_W-1:0] r7_rhs [3];
    logic [2:0]            r7_sep;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int p = 0; p < 4; p++) begin
                n7_sp[k][p] = r6_neg[k][p] ? -$signed({1'b0, r6_mag[k][p]})
                                           : $signed({1'b0, r6_mag[k][p]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_sep <= r6_sep;
            for (int k = 0; k < 3; k++) begin
                r7_lhs[k] <= S_W'(n7_sp[k][0]) - S_W'(n7_sp[k][1]);
                r7_rhs[k] <= S_W'(n7_sp[k][2]) + S_W'(n7_sp[k][3]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: |lhs| > rhs on each cross axis, result register
    // ------------------------------------------------------------------
    logic [S_W-1:0] n8_alhs [3];
    logic [2:0]     n8_xsep;
    logic           r8_hit;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n8_alhs[k] = r7_lhs[k][S_W-1] ? S_W'(-r7_lhs[k]) : S_W'(r7_lhs[k]);
            n8_xsep[k] = $signed({1'b0, n8_alhs[k]}) > (S_W+1)'(r7_rhs[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r8_hit <= !(|r7_sep) && !(|n8_xsep);
        end
    end

    assign o_hit = r8_hit;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input is refused only when every stage is full and the output stalls
    `SBOT_ASSERT_NOW(a_full_when_refused, i_clk, i_rst_n, !o_in_ready, (&r_v) && !i_out_ready, "input refused with a free stage")
    // an accepted item occupies the first stage next cycle
    `SBOT_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v[1], "accepted item not captured")
    // a world axis separation always yields a miss
    `SBOT_ASSERT_NEXT(a_axis_sep_miss, i_clk, i_rst_n, r_v[7] && en[8] && (|r7_sep), !o_hit, "axis separation reported as hit")

endmodule

`default_nettype wire
